// ===== sv/gidi_pkg.sv =====
// Shared constants, codes and types of the grid inverse-distance interpolator.
package gidi_pkg;

	localparam int POINTS_PER_AXIS = 16;
	localparam int COORD_BITS      = 32;

	localparam int VALUE_BITS      = 32;
	localparam int SPACING_BITS    = 31;
	localparam int COUNT_BITS      = 4;
	localparam int INDEX_BITS      = 4;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_INDEX_BITS  = 3;

	// kind, three write indices and the value pair ahead of the coordinates
	localparam int ENTRY_FIXED_BITS = 2 + 3 * INDEX_BITS + 2 * VALUE_BITS;

	localparam int WEIGHT_SHIFT    = 24;
	localparam int WEIGHT_BITS     = WEIGHT_SHIFT + 1;
	localparam int WSUM_BITS       = WEIGHT_SHIFT + 4;
	localparam int STEP_BITS       = 6;
	localparam int SQRT_STEPS      = 32;
	localparam int DIV_AXIS_BITS   = 4;
	localparam int DIV_FIN_BITS    = 32;

	localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;
	localparam logic [SPACING_BITS-1:0] SPACING_RESET = 31'd65536;

	localparam logic [CFG_INDEX_BITS-1:0] REG_X_ORIGIN   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Y_ORIGIN   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Z_ORIGIN   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_X_SPACING  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Y_SPACING  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_Z_SPACING  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_COUNT = 3'd6;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_QUERY,
		KIND_OOR
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AX_START,
		ST_AX_WAIT,
		ST_AX_LO,
		ST_AX_DX,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_NB_CHK,
		ST_SQRT_WAIT,
		ST_WT_START,
		ST_WT_WAIT,
		ST_ACC_R,
		ST_ACC_I,
		ST_FIN_R,
		ST_FIN_R_WAIT,
		ST_FIN_I,
		ST_FIN_I_WAIT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic                 is_sqrt;
		logic [STEP_BITS-1:0] nbits;
	} iter_req_t;

endpackage

// ===== sv/gidi_fifo.sv =====
// Two-entry item queue between the front and the back.
module gidi_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= din;
	end

	assign dout  = slot_q[rp_q];
	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;

endmodule

// ===== sv/gidi_front.sv =====
// Front: configuration registers, item intake and bounds classification.
module gidi_front #(
	parameter int POINTS_PER_AXIS = gidi_pkg::POINTS_PER_AXIS,
	parameter int COORD_BITS      = gidi_pkg::COORD_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic full,
	input  logic command,
	input  logic [gidi_pkg::INDEX_BITS-1:0] entry_x_index,
	input  logic [gidi_pkg::INDEX_BITS-1:0] entry_y_index,
	input  logic [gidi_pkg::INDEX_BITS-1:0] entry_z_index,
	input  logic [gidi_pkg::VALUE_BITS-1:0] entry_radiation,
	input  logic [gidi_pkg::VALUE_BITS-1:0] entry_interaction,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] query_z,
	input  logic cfg_we,
	input  logic [gidi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gidi_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic push,
	output logic [3*COORD_BITS+gidi_pkg::ENTRY_FIXED_BITS-1:0] entry,
	output logic [2:0][COORD_BITS-1:0] org,
	output logic [2:0][gidi_pkg::SPACING_BITS-1:0] sp,
	output logic [2:0][gidi_pkg::COUNT_BITS-1:0] cnt
);

	localparam int XW = COORD_BITS + 37;

	logic [2:0][COORD_BITS-1:0]              org_q;
	logic [2:0][gidi_pkg::SPACING_BITS-1:0]  sp_q;
	logic [3*gidi_pkg::COUNT_BITS-1:0]       cnt_q;
	logic [COORD_BITS+gidi_pkg::CFG_DATA_BITS-1:0] org_wide;
	logic [2:0][COORD_BITS-1:0]              qv;
	logic                                    oor;
	gidi_pkg::kind_t                         kind;

	assign org_wide = {{COORD_BITS{1'b0}}, cfg_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '0;
			sp_q  <= {3{gidi_pkg::SPACING_RESET}};
			cnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gidi_pkg::REG_X_ORIGIN:   org_q[0] <= org_wide[COORD_BITS-1:0];
				gidi_pkg::REG_Y_ORIGIN:   org_q[1] <= org_wide[COORD_BITS-1:0];
				gidi_pkg::REG_Z_ORIGIN:   org_q[2] <= org_wide[COORD_BITS-1:0];
				gidi_pkg::REG_X_SPACING:  sp_q[0] <= cfg_data[gidi_pkg::SPACING_BITS-1:0];
				gidi_pkg::REG_Y_SPACING:  sp_q[1] <= cfg_data[gidi_pkg::SPACING_BITS-1:0];
				gidi_pkg::REG_Z_SPACING:  sp_q[2] <= cfg_data[gidi_pkg::SPACING_BITS-1:0];
				gidi_pkg::REG_STEP_COUNT: cnt_q <= cfg_data[3*gidi_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// zero spacing acts as one; counts saturate to the last grid point
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			org[a] = org_q[a];
			sp[a]  = (sp_q[a] == '0) ? gidi_pkg::SPACING_BITS'(1) : sp_q[a];
			if (32'(cnt_q[a*4 +: 4]) > POINTS_PER_AXIS - 1)
				cnt[a] = gidi_pkg::COUNT_BITS'(POINTS_PER_AXIS - 1);
			else
				cnt[a] = cnt_q[a*4 +: 4];
		end
	end

	assign qv = {query_z, query_y, query_x};

	always_comb begin
		logic signed [XW-1:0] qe;
		logic signed [XW-1:0] oe;
		logic signed [XW-1:0] hi;
		oor = 1'b0;
		for (int a = 0; a < 3; a++) begin
			qe = $signed({{37{qv[a][COORD_BITS-1]}}, qv[a]});
			oe = $signed({{37{org[a][COORD_BITS-1]}}, org[a]});
			hi = oe + $signed({{(XW-35){1'b0}}, 35'(cnt[a]) * 35'(sp[a])});
			if ((qe + XW'(1) < oe) || (qe - XW'(1) > hi)) oor = 1'b1;
		end
	end

	always_comb begin
		if (command == gidi_pkg::CMD_WRITE) kind = gidi_pkg::KIND_WRITE;
		else if (oor) kind = gidi_pkg::KIND_OOR;
		else kind = gidi_pkg::KIND_QUERY;
	end

	assign push  = start && !full;
	assign entry = {kind, entry_x_index, entry_y_index, entry_z_index,
		entry_radiation, entry_interaction, query_x, query_y, query_z};

endmodule

// ===== sv/gidi_iter.sv =====
// Shared iterative unit: restoring divide or integer square root, one bit a cycle.
module gidi_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  gidi_pkg::iter_req_t req,
	input  logic [63:0]         num,
	input  logic [32:0]         den,
	output logic                done,
	output logic [31:0]         res
);

	logic                          busy_q;
	logic                          done_q;
	logic [gidi_pkg::STEP_BITS-1:0] cnt_q;
	logic                          is_sqrt_q;
	logic [63:0]                   rem_q;
	logic [63:0]                   res_q;
	logic [63:0]                   bit_q;
	logic [64:0]                   dsh_q;
	logic [64:0]                   trial;
	logic                          ge;

	assign trial = is_sqrt_q ? ({1'b0, res_q} + {1'b0, bit_q}) : dsh_q;
	assign ge    = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == gidi_pkg::STEP_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - gidi_pkg::STEP_BITS'(1);
				if (cnt_q == gidi_pkg::STEP_BITS'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			is_sqrt_q <= req.is_sqrt;
			rem_q     <= num;
			res_q     <= '0;
			bit_q     <= gidi_pkg::SQRT_TOP;
			dsh_q     <= {32'd0, den} << (req.nbits - gidi_pkg::STEP_BITS'(1));
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - trial[63:0];
			if (is_sqrt_q) begin
				res_q <= ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
				bit_q <= bit_q >> 2;
			end else begin
				res_q <= {res_q[62:0], ge};
				dsh_q <= dsh_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q[31:0];

endmodule

// ===== sv/gidi_back.sv =====
// Back: grid memory, neighbour walk and weighted averaging sequencer.
module gidi_back #(
	parameter int POINTS_PER_AXIS = gidi_pkg::POINTS_PER_AXIS,
	parameter int COORD_BITS      = gidi_pkg::COORD_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  logic [3*COORD_BITS+gidi_pkg::ENTRY_FIXED_BITS-1:0] head,
	output logic pop,
	input  logic [2:0][COORD_BITS-1:0] org,
	input  logic [2:0][gidi_pkg::SPACING_BITS-1:0] sp,
	input  logic [2:0][gidi_pkg::COUNT_BITS-1:0] cnt,
	output logic done,
	output logic [gidi_pkg::VALUE_BITS-1:0] radiation_length,
	output logic [gidi_pkg::VALUE_BITS-1:0] interaction_length,
	output logic out_of_range
);

	localparam int W     = 3 * COORD_BITS + gidi_pkg::ENTRY_FIXED_BITS;
	localparam int DEPTH = POINTS_PER_AXIS * POINTS_PER_AXIS * POINTS_PER_AXIS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = COORD_BITS + 37;
	localparam int CW    = gidi_pkg::COUNT_BITS;

	// head fields
	gidi_pkg::kind_t           h_kind;
	logic [3:0]                h_ix, h_iy, h_iz;
	logic [31:0]               h_rad, h_int;
	logic [2:0][COORD_BITS-1:0] h_q;

	assign h_kind = gidi_pkg::kind_t'(head[W-1 -: 2]);
	assign h_ix   = head[W-3 -: 4];
	assign h_iy   = head[W-7 -: 4];
	assign h_iz   = head[W-11 -: 4];
	assign h_rad  = head[W-15 -: 32];
	assign h_int  = head[W-47 -: 32];
	assign h_q    = {head[COORD_BITS-1:0], head[2*COORD_BITS-1 -: COORD_BITS],
		head[3*COORD_BITS-1 -: COORD_BITS]};

	gidi_pkg::state_t state_q, state_d;

	logic [2:0][COORD_BITS-1:0] q_q;
	logic [1:0]                 ax_q;
	logic [2:0][CW-1:0]         i0_q;
	logic [2:0][1:0][31:0]      dl_q;
	logic [2:0]                 nv_q;
	logic signed [XW-1:0]       lo_q;
	logic [2:0]                 nb_q;
	logic [3:0]                 k_q;
	logic [3:0]                 j_q;
	logic [63:0]                acc_q;
	logic [7:0][63:0]           val_q;
	logic [7:0][31:0]           dist_q;
	logic [31:0]                dmin_q;
	logic [gidi_pkg::WEIGHT_BITS-1:0] w_q;
	logic [63:0]                rsum_q;
	logic [63:0]                isum_q;
	logic [gidi_pkg::WSUM_BITS-1:0] wsum_q;
	logic [31:0]                rad_res_q;

	logic        done_q;
	logic [31:0] rad_q, int_q;
	logic        oor_q;

	// grid memory
	logic [63:0] mem [DEPTH];
	logic [63:0] rd_q;
	logic        mem_we;
	logic [AW-1:0] wr_adr, rd_adr;
	logic        in_grid;

	assign in_grid = (32'(h_ix) < POINTS_PER_AXIS) && (32'(h_iy) < POINTS_PER_AXIS)
		&& (32'(h_iz) < POINTS_PER_AXIS);
	assign wr_adr = AW'((32'(h_ix) * POINTS_PER_AXIS + 32'(h_iy)) * POINTS_PER_AXIS
		+ 32'(h_iz));
	assign rd_adr = AW'((32'(i0_q[0] + CW'(nb_q[0])) * POINTS_PER_AXIS
		+ 32'(i0_q[1] + CW'(nb_q[1]))) * POINTS_PER_AXIS + 32'(i0_q[2] + CW'(nb_q[2])));

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_adr] <= {h_rad, h_int};
		rd_q <= mem[rd_adr];
	end

	// shared iterative unit
	gidi_pkg::iter_req_t iter_req;
	logic [63:0] iter_num;
	logic [32:0] iter_den;
	logic        iter_done;
	logic [31:0] iter_res;

	gidi_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iter_req),
		.num    (iter_num),
		.den    (iter_den),
		.done   (iter_done),
		.res    (iter_res)
	);

	// per-axis corner search
	logic signed [COORD_BITS:0] d_ax;
	logic [63:0]                d_num;
	logic                       d_neg, d_sat;
	logic [gidi_pkg::SPACING_BITS-1:0] sp_a;
	logic [CW-1:0]              cnt_a;
	logic [COORD_BITS-1:0]      org_a, q_a;

	assign org_a = org[ax_q];
	assign q_a   = q_q[ax_q];
	assign sp_a  = sp[ax_q];
	assign cnt_a = cnt[ax_q];
	assign d_ax  = $signed({q_a[COORD_BITS-1], q_a}) - $signed({org_a[COORD_BITS-1], org_a});
	assign d_neg = d_ax[COORD_BITS];
	assign d_num = {{(63-COORD_BITS){1'b0}}, d_ax};
	assign d_sat = d_num >= {29'd0, sp_a, 4'd0};

	logic signed [XW-1:0] qe, t0, t1;
	logic [31:0] dx0, dx1;

	assign qe  = $signed({{37{q_a[COORD_BITS-1]}}, q_a});
	assign t0  = qe - lo_q;
	assign t1  = lo_q + $signed({{(XW-gidi_pkg::SPACING_BITS){1'b0}}, sp_a}) - qe;
	assign dx0 = t0[XW-1] ? 32'(-t0) : t0[31:0];
	assign dx1 = t1[XW-1] ? 32'(-t1) : t1[31:0];

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	assign prod = mul_a * mul_b;

	logic [2:0] nb_next;
	logic       nb_last;

	assign nb_last = (nb_q[0] | ~nv_q[0]) & (nb_q[1] | ~nv_q[1]) & (nb_q[2] | ~nv_q[2]);

	always_comb begin
		nb_next = nb_q;
		if (nv_q[2] && !nb_q[2]) begin
			nb_next[2] = 1'b1;
		end else if (nv_q[1] && !nb_q[1]) begin
			nb_next[1] = 1'b1;
			nb_next[2] = 1'b0;
		end else begin
			nb_next = 3'b001;
		end
	end

	logic        emit;
	logic [31:0] emit_rad, emit_int;
	logic        emit_oor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gidi_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		iter_req = '0;
		iter_num = '0;
		iter_den = '0;
		mul_a    = '0;
		mul_b    = '0;
		emit     = 1'b0;
		emit_rad = '0;
		emit_int = '0;
		emit_oor = 1'b0;
		case (state_q)
			gidi_pkg::ST_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (h_kind)
						gidi_pkg::KIND_WRITE: mem_we = in_grid;
						gidi_pkg::KIND_QUERY: state_d = gidi_pkg::ST_AX_START;
						gidi_pkg::KIND_OOR: begin
							emit     = 1'b1;
							emit_oor = 1'b1;
						end
						default: ;
					endcase
				end
			end
			gidi_pkg::ST_AX_START: begin
				if (d_neg || d_sat) begin
					state_d = gidi_pkg::ST_AX_LO;
				end else begin
					iter_req.start = 1'b1;
					iter_req.nbits = gidi_pkg::STEP_BITS'(gidi_pkg::DIV_AXIS_BITS);
					iter_num       = d_num;
					iter_den       = {2'b0, sp_a};
					state_d        = gidi_pkg::ST_AX_WAIT;
				end
			end
			gidi_pkg::ST_AX_WAIT: if (iter_done) state_d = gidi_pkg::ST_AX_LO;
			gidi_pkg::ST_AX_LO: state_d = gidi_pkg::ST_AX_DX;
			gidi_pkg::ST_AX_DX: begin
				state_d = (ax_q == 2'd2) ? gidi_pkg::ST_SQ0 : gidi_pkg::ST_AX_START;
			end
			gidi_pkg::ST_SQ0: begin
				mul_a   = dl_q[0][nb_q[0]];
				mul_b   = dl_q[0][nb_q[0]];
				state_d = gidi_pkg::ST_SQ1;
			end
			gidi_pkg::ST_SQ1: begin
				mul_a   = dl_q[1][nb_q[1]];
				mul_b   = dl_q[1][nb_q[1]];
				state_d = gidi_pkg::ST_SQ2;
			end
			gidi_pkg::ST_SQ2: begin
				mul_a   = dl_q[2][nb_q[2]];
				mul_b   = dl_q[2][nb_q[2]];
				state_d = gidi_pkg::ST_NB_CHK;
			end
			gidi_pkg::ST_NB_CHK: begin
				if (acc_q == '0) begin
					// query sits on this grid point: return its pair as is
					emit     = 1'b1;
					emit_rad = rd_q[63:32];
					emit_int = rd_q[31:0];
					state_d  = gidi_pkg::ST_IDLE;
				end else begin
					iter_req.start   = 1'b1;
					iter_req.is_sqrt = 1'b1;
					iter_req.nbits   = gidi_pkg::STEP_BITS'(gidi_pkg::SQRT_STEPS);
					iter_num         = acc_q;
					state_d          = gidi_pkg::ST_SQRT_WAIT;
				end
			end
			gidi_pkg::ST_SQRT_WAIT: begin
				if (iter_done) state_d = nb_last ? gidi_pkg::ST_WT_START : gidi_pkg::ST_SQ0;
			end
			gidi_pkg::ST_WT_START: begin
				iter_req.start = 1'b1;
				iter_req.nbits = gidi_pkg::STEP_BITS'(gidi_pkg::WEIGHT_BITS);
				iter_num       = {8'd0, dmin_q, 24'd0};
				iter_den       = {1'b0, dist_q[j_q[2:0]]};
				state_d        = gidi_pkg::ST_WT_WAIT;
			end
			gidi_pkg::ST_WT_WAIT: if (iter_done) state_d = gidi_pkg::ST_ACC_R;
			gidi_pkg::ST_ACC_R: begin
				mul_a   = val_q[j_q[2:0]][63:32];
				mul_b   = {7'd0, w_q};
				state_d = gidi_pkg::ST_ACC_I;
			end
			gidi_pkg::ST_ACC_I: begin
				mul_a   = val_q[j_q[2:0]][31:0];
				mul_b   = {7'd0, w_q};
				state_d = (j_q + 4'd1 == k_q) ? gidi_pkg::ST_FIN_R : gidi_pkg::ST_WT_START;
			end
			gidi_pkg::ST_FIN_R: begin
				iter_req.start = 1'b1;
				iter_req.nbits = gidi_pkg::STEP_BITS'(gidi_pkg::DIV_FIN_BITS);
				iter_num       = rsum_q + 64'(wsum_q >> 1);
				iter_den       = 33'(wsum_q);
				state_d        = gidi_pkg::ST_FIN_R_WAIT;
			end
			gidi_pkg::ST_FIN_R_WAIT: if (iter_done) state_d = gidi_pkg::ST_FIN_I;
			gidi_pkg::ST_FIN_I: begin
				iter_req.start = 1'b1;
				iter_req.nbits = gidi_pkg::STEP_BITS'(gidi_pkg::DIV_FIN_BITS);
				iter_num       = isum_q + 64'(wsum_q >> 1);
				iter_den       = 33'(wsum_q);
				state_d        = gidi_pkg::ST_FIN_I_WAIT;
			end
			gidi_pkg::ST_FIN_I_WAIT: begin
				if (iter_done) begin
					emit     = 1'b1;
					emit_rad = rad_res_q;
					emit_int = iter_res;
					state_d  = gidi_pkg::ST_IDLE;
				end
			end
			default: state_d = gidi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gidi_pkg::ST_IDLE: begin
				q_q  <= h_q;
				ax_q <= 2'd0;
			end
			gidi_pkg::ST_AX_START: begin
				if (d_neg) i0_q[ax_q] <= '0;
				else if (d_sat) i0_q[ax_q] <= cnt_a;
			end
			gidi_pkg::ST_AX_WAIT: begin
				if (iter_done) i0_q[ax_q] <= (iter_res[CW-1:0] > cnt_a) ? cnt_a : iter_res[CW-1:0];
			end
			gidi_pkg::ST_AX_LO: begin
				lo_q <= $signed({{37{org_a[COORD_BITS-1]}}, org_a})
					+ $signed({{(XW-35){1'b0}}, 35'(i0_q[ax_q]) * 35'(sp_a)});
			end
			gidi_pkg::ST_AX_DX: begin
				dl_q[ax_q][0] <= dx0;
				dl_q[ax_q][1] <= dx1;
				nv_q[ax_q]    <= i0_q[ax_q] < cnt_a;
				ax_q          <= ax_q + 2'd1;
				nb_q          <= '0;
				k_q           <= '0;
			end
			gidi_pkg::ST_SQ0: acc_q <= prod;
			gidi_pkg::ST_SQ1: acc_q <= acc_q + prod;
			gidi_pkg::ST_SQ2: acc_q <= acc_q + prod;
			gidi_pkg::ST_NB_CHK: val_q[k_q[2:0]] <= rd_q;
			gidi_pkg::ST_SQRT_WAIT: begin
				if (iter_done) begin
					dist_q[k_q[2:0]] <= iter_res;
					if (k_q == '0 || iter_res < dmin_q) dmin_q <= iter_res;
					k_q    <= k_q + 4'd1;
					nb_q   <= nb_next;
					j_q    <= '0;
					rsum_q <= '0;
					isum_q <= '0;
					wsum_q <= '0;
				end
			end
			gidi_pkg::ST_WT_WAIT: begin
				if (iter_done) begin
					w_q <= (iter_res[gidi_pkg::WEIGHT_BITS-1:0] == '0)
						? gidi_pkg::WEIGHT_BITS'(1) : iter_res[gidi_pkg::WEIGHT_BITS-1:0];
				end
			end
			gidi_pkg::ST_ACC_R: begin
				rsum_q <= rsum_q + prod;
				wsum_q <= wsum_q + gidi_pkg::WSUM_BITS'(w_q);
			end
			gidi_pkg::ST_ACC_I: begin
				isum_q <= isum_q + prod;
				j_q    <= j_q + 4'd1;
			end
			gidi_pkg::ST_FIN_R_WAIT: if (iter_done) rad_res_q <= iter_res;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rad_q <= emit_rad;
			int_q <= emit_int;
			oor_q <= emit_oor;
		end
	end

	assign done               = done_q;
	assign radiation_length   = rad_q;
	assign interaction_length = int_q;
	assign out_of_range       = oor_q;

endmodule

// ===== sv/grid_inverse_distance_interpolator_top.sv =====
// Top level of the grid inverse-distance interpolator.
//
//  channel   handshake           payload
//  item in   start, busy         command, entry_*, query_x/y/z
//  result    done (one cycle)    radiation_length, interaction_length, out_of_range
//  config    cfg_we              cfg_index, cfg_data
//
// An item is taken when start is high and busy is low; busy rises only when the
// two-entry queue between front and back is full. A grid write is stored at the edge
// that takes it out of the queue, and an out-of-bounds query is answered by a
// registered strobe set by that edge. An in-bounds query is answered after the back
// has walked its kept neighbours through the shared divide/square-root unit, which
// resolves one bit a cycle.
// arst_n clears all control state; the grid memory is not cleared and holds
// whatever was written. Results cannot be held off by the receiver.
module grid_inverse_distance_interpolator_top #(
	parameter int POINTS_PER_AXIS = gidi_pkg::POINTS_PER_AXIS,
	parameter int COORD_BITS      = gidi_pkg::COORD_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic command,
	input  logic [gidi_pkg::INDEX_BITS-1:0] entry_x_index,
	input  logic [gidi_pkg::INDEX_BITS-1:0] entry_y_index,
	input  logic [gidi_pkg::INDEX_BITS-1:0] entry_z_index,
	input  logic [gidi_pkg::VALUE_BITS-1:0] entry_radiation,
	input  logic [gidi_pkg::VALUE_BITS-1:0] entry_interaction,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] query_z,
	input  logic cfg_we,
	input  logic [gidi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gidi_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic done,
	output logic [gidi_pkg::VALUE_BITS-1:0] radiation_length,
	output logic [gidi_pkg::VALUE_BITS-1:0] interaction_length,
	output logic out_of_range
);

	localparam int W = 3 * COORD_BITS + gidi_pkg::ENTRY_FIXED_BITS;

	logic         push, pop, full, empty;
	logic [W-1:0] entry, head;
	logic [2:0][COORD_BITS-1:0]             org;
	logic [2:0][gidi_pkg::SPACING_BITS-1:0] sp;
	logic [2:0][gidi_pkg::COUNT_BITS-1:0]   cnt;

	gidi_front #(
		.POINTS_PER_AXIS (POINTS_PER_AXIS),
		.COORD_BITS      (COORD_BITS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.full              (full),
		.command           (command),
		.entry_x_index     (entry_x_index),
		.entry_y_index     (entry_y_index),
		.entry_z_index     (entry_z_index),
		.entry_radiation   (entry_radiation),
		.entry_interaction (entry_interaction),
		.query_x           (query_x),
		.query_y           (query_y),
		.query_z           (query_z),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.push              (push),
		.entry             (entry),
		.org               (org),
		.sp                (sp),
		.cnt               (cnt)
	);

	gidi_fifo #(
		.W (W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.pop    (pop),
		.dout   (head),
		.full   (full),
		.empty  (empty)
	);

	gidi_back #(
		.POINTS_PER_AXIS (POINTS_PER_AXIS),
		.COORD_BITS      (COORD_BITS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.empty              (empty),
		.head               (head),
		.pop                (pop),
		.org                (org),
		.sp                 (sp),
		.cnt                (cnt),
		.done               (done),
		.radiation_length   (radiation_length),
		.interaction_length (interaction_length),
		.out_of_range       (out_of_range)
	);

	assign busy = full;

endmodule

// ===== sv/gidi_checker.sv =====
// Port-level checks on the interpolator, bound to the top level.
module gidi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] radiation_length,
	input logic [31:0] interaction_length,
	input logic        out_of_range
);

	// every result carries fully known values
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({radiation_length, interaction_length, out_of_range}))
		else $error("result carries unknown bits");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (radiation_length == 32'd0 && interaction_length == 32'd0))
		else $error("out-of-range result carries non-zero values");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an item offered");

endmodule

bind grid_inverse_distance_interpolator_top gidi_checker u_chk (.*);
